[rtl/core/srdc_pkg.sv]
// ----------------------------------------------------------------------------
// srdc_pkg
// shared types and constants of the scan report dedup cache
// ----------------------------------------------------------------------------
package srdc_pkg;

  localparam int TableDepthDef = 64;
  localparam int AddrW         = 48;
  localparam int DbmW          = 8;
  localparam int LenW          = 6;
  localparam int SlotW         = 6;

  typedef enum logic {
    OP_REPORT = 1'b0,
    OP_FLUSH  = 1'b1
  } op_e;

  typedef enum logic {
    KIND_ACK   = 1'b0,
    KIND_ENTRY = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_WRITE,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic                   op;
    logic [AddrW-1:0]       dev_addr;
    logic signed [DbmW-1:0] signal_dbm;
    logic [LenW-1:0]        payload_len;
  } in_t;

  typedef struct packed {
    logic                   kind;
    logic [SlotW-1:0]       slot;
    logic                   hit;
    logic [AddrW-1:0]       out_addr;
    logic signed [DbmW-1:0] out_dbm;
    logic [LenW-1:0]        out_len;
    logic                   last;
  } out_t;

  typedef struct packed {
    logic [AddrW-1:0]       addr;
    logic signed [DbmW-1:0] dbm;
    logic [LenW-1:0]        len;
  } entry_t;

endpackage

[rtl/core/srdc_store.sv]
// ----------------------------------------------------------------------------
// srdc_store
// entry memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module srdc_store #(
  parameter int Depth = srdc_pkg::TableDepthDef
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_idx_i,
  input  srdc_pkg::entry_t         wr_data_i,
  input  logic [$clog2(Depth)-1:0] rd_idx_i,
  output srdc_pkg::entry_t         rd_data_o
);
  import srdc_pkg::*;

  entry_t mem_q [Depth];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_idx_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/core/scan_report_dedup_cache.sv]
// ----------------------------------------------------------------------------
// scan_report_dedup_cache
// dedup table of advertiser reports keyed by 48-bit device address
// ----------------------------------------------------------------------------
// report: accepted, then compared against the filled entries in slot order
//   up to a hit or the last filled entry, then written when the output is free
// flush: accepted, then one word per filled entry; an empty flush emits none
// one item at a time; the entry memory's single read port sets the pace
// reset clears the state machine, fill count and output valid; the memory
//   itself is not cleared, only slots below the fill count are ever used
module scan_report_dedup_cache #(
  parameter int TableDepth = srdc_pkg::TableDepthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  srdc_pkg::in_t in_word_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output srdc_pkg::out_t out_word_o
);
  import srdc_pkg::*;

  // index width and fill count width (count must reach TableDepth)
  localparam int IdxW  = $clog2(TableDepth);
  localparam int CntW  = $clog2(TableDepth + 1);
  localparam int WideW = (IdxW > SlotW) ? IdxW : SlotW;

  // sequencer state
  state_e          state_q, state_d;
  logic [IdxW-1:0] cmp_q, cmp_d;     // entry whose data sits in the read register
  logic            hit_q, hit_d;
  logic [CntW-1:0] fill_q, fill_d;
  in_t             item_q;

  // output register
  logic            out_valid_q, out_valid_d;
  out_t            out_q, out_d;

  // memory port signals
  logic            wr_en;
  logic [IdxW-1:0] wr_idx;
  entry_t          wr_data;
  logic [IdxW-1:0] rd_idx;
  entry_t          rd_data;

  logic            in_acc;
  logic            out_free;
  logic            last_idx;
  logic            full;
  logic [IdxW-1:0] miss_slot;
  logic            emit;
  logic [IdxW-1:0] emit_idx;
  logic [WideW-1:0] slot_wide;

  srdc_store #(
    .Depth(TableDepth)
  ) u_store (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_idx_i (wr_idx),
    .wr_data_i(wr_data),
    .rd_idx_i (rd_idx),
    .rd_data_o(rd_data)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && (state_q == ST_IDLE);

  // output register can take a word this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  // entry under compare is the last filled one
  assign last_idx = ((CntW'(cmp_q) + CntW'(1)) == fill_q);

  // on a miss with a full table the last slot is reused
  assign full      = (fill_q == CntW'(TableDepth));
  assign miss_slot = full ? IdxW'(TableDepth - 1) : fill_q[IdxW-1:0];

  assign wr_idx    = hit_q ? cmp_q : miss_slot;
  assign wr_data   = '{addr: item_q.dev_addr, dbm: item_q.signal_dbm,
                       len: item_q.payload_len};

  assign emit_idx  = (state_q == ST_FLUSH) ? cmp_q : wr_idx;
  assign slot_wide = WideW'(emit_idx);

  always_comb begin
    state_d = state_q;
    cmp_d   = cmp_q;
    hit_d   = hit_q;
    fill_d  = fill_q;
    rd_idx  = '0;
    wr_en   = 1'b0;
    emit    = 1'b0;
    out_d   = out_q;

    unique case (state_q)
      ST_IDLE: begin
        // entry 0 is read on accept so the compare can start next cycle
        if (in_acc) begin
          cmp_d = '0;
          hit_d = 1'b0;
          if (in_word_i.op == OP_FLUSH) begin
            if (fill_q != '0) begin
              state_d = ST_FLUSH;
            end
          end else if (fill_q == '0) begin
            state_d = ST_WRITE;
          end else begin
            state_d = ST_SEARCH;
          end
        end
      end

      ST_SEARCH: begin
        if (rd_data.addr == item_q.dev_addr) begin
          hit_d   = 1'b1;
          state_d = ST_WRITE;
        end else if (last_idx) begin
          state_d = ST_WRITE;
        end else begin
          cmp_d  = cmp_q + IdxW'(1);
          rd_idx = cmp_q + IdxW'(1);
        end
      end

      ST_WRITE: begin
        if (out_free) begin
          wr_en = 1'b1;
          emit  = 1'b1;
          out_d = '{kind: KIND_ACK, slot: slot_wide[SlotW-1:0], hit: hit_q,
                    out_addr: item_q.dev_addr, out_dbm: item_q.signal_dbm,
                    out_len: item_q.payload_len, last: 1'b1};
          if (!hit_q) begin
            fill_d = CntW'(miss_slot) + CntW'(1);
          end
          state_d = ST_IDLE;
        end
      end

      ST_FLUSH: begin
        if (out_free) begin
          emit   = 1'b1;
          out_d  = '{kind: KIND_ENTRY, slot: slot_wide[SlotW-1:0], hit: 1'b0,
                     out_addr: rd_data.addr, out_dbm: rd_data.dbm,
                     out_len: rd_data.len, last: last_idx};
          rd_idx = cmp_q + IdxW'(1);
          if (last_idx) begin
            fill_d  = '0;
            state_d = ST_IDLE;
          end else begin
            cmp_d = cmp_q + IdxW'(1);
          end
        end else begin
          // stalled: keep re-reading the same entry
          rd_idx = cmp_q;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cmp_q       <= '0;
      hit_q       <= 1'b0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cmp_q       <= cmp_d;
      hit_q       <= hit_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_word_i;
    end
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

`ifndef NO_ASSERTIONS
  // fill count never passes the table depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(TableDepth))
    else $error("fill count above table depth");

  // the compare pointer stays inside the filled part of the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH || state_q == ST_FLUSH) |-> (CntW'(cmp_q) < fill_q))
    else $error("compare pointer beyond fill count");

  // a report write always shows up as a valid word next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRITE && out_free) |=> (out_valid_o && out_word_o.last))
    else $error("report ack not presented");

  // emitting the last flushed entry empties the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH && out_free && last_idx) |=> (fill_q == '0))
    else $error("table not emptied after flush");

  // a stalled output word is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !emit)
    else $error("output word overwritten while stalled");
`endif

endmodule

[sim/scan_report_dedup_cache_tb.sv]
// ----------------------------------------------------------------------------
// scan_report_dedup_cache_tb
// self-checking bench for the advertiser report dedup table: a table model
// predicts every acknowledgement and flushed entry, random idling on both
// sides, one long output hold-off that backs the block up, table overflow runs
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module scan_report_dedup_cache_tb;
  import srdc_pkg::*;

  localparam int TableDepth = TableDepthDef;
  localparam int ItemTarget = 460;
  localparam int CalmFrom   = 400;  // no idling from this item on
  localparam int PoolSize   = 96;

  // table model: own copy of the entries and fill count, queue of due words
  class dedup_table_model;
    entry_t      entries [TableDepth];
    int unsigned filled;
    out_t        due_words [$];
    int unsigned faults;
    int unsigned seen;

    function new();
      filled = 0;
      faults = 0;
      seen   = 0;
    endfunction

    function int unsigned pending();
      return due_words.size();
    endfunction

    function void push_due(kind_e kind, int unsigned slot, logic hit, logic last);
      out_t w;
      w.kind     = kind;
      w.slot     = SlotW'(slot);
      w.hit      = hit;
      w.out_addr = entries[slot].addr;
      w.out_dbm  = entries[slot].dbm;
      w.out_len  = entries[slot].len;
      w.last     = last;
      due_words.push_back(w);
    endfunction

    // report: search in slot order, append on miss, last slot reused when full
    // flush: every filled slot in order, last one marked, table emptied
    function void accept_word(in_t w);
      int unsigned slot;
      logic        hit;
      slot = 0;
      hit  = 1'b0;
      if (w.op == OP_REPORT) begin
        for (int unsigned i = 0; i < filled; i++) begin
          if (entries[i].addr == w.dev_addr) begin
            slot = i;
            hit  = 1'b1;
            break;
          end
        end
        if (!hit) begin
          if (filled == TableDepth) filled = TableDepth - 1;
          slot = filled;
          filled++;
          entries[slot].addr = w.dev_addr;
        end
        entries[slot].dbm = w.signal_dbm;
        entries[slot].len = w.payload_len;
        push_due(KIND_ACK, slot, hit, 1'b1);
      end else begin
        for (int unsigned i = 0; i < filled; i++)
          push_due(KIND_ENTRY, i, 1'b0, (i + 1 == filled));
        filled = 0;
      end
    endfunction

    function string word_text(out_t w);
      return $sformatf("kind=%0d slot=%0d hit=%0d addr=%h dbm=%0d len=%0d last=%0d",
                       w.kind, w.slot, w.hit, w.out_addr, $signed(w.out_dbm),
                       w.out_len, w.last);
    endfunction

    function void check_word(out_t got);
      out_t want;
      seen++;
      if (due_words.size() == 0) begin
        faults++;
        if (faults <= 10) $display("result %0d with nothing due: %s", seen, word_text(got));
        return;
      end
      want = due_words.pop_front();
      if (got.kind !== want.kind || got.slot !== want.slot || got.hit !== want.hit ||
          got.out_addr !== want.out_addr || got.out_dbm !== want.out_dbm ||
          got.out_len !== want.out_len || got.last !== want.last) begin
        faults++;
        if (faults <= 10) begin
          $display("mismatch on result %0d", seen);
          $display("  expected %s", word_text(want));
          $display("  actual   %s", word_text(got));
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  logic in_valid;
  logic in_stall;
  in_t  in_word;
  logic out_valid;
  logic out_stall;
  out_t out_word;

  dedup_table_model model = new();

  bit          idle_en;      // random gaps on both sides
  int unsigned hold_cycles;  // nonzero asks the receiver for one long hold-off
  int unsigned items_sent;

  always #5 clk_i = ~clk_i;

  scan_report_dedup_cache #(
    .TableDepth (TableDepth)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  // both handshakes sampled at the rising edge; results checked before the
  // new input is noted, although an item is never answered in the cycle it is taken
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && !out_stall) model.check_word(out_word);
      if (in_valid && !in_stall) model.accept_word(in_word);
    end
  end

  // receiver side: random stall bursts, plus the long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(negedge clk_i);
        hold_cycles = 0;
        out_stall <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  // offer one word, starting at a falling edge, return at the falling edge
  // after it was taken; valid stays high into the next call unless a gap
  task automatic send_word(input in_t w);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  function automatic in_t report_word(logic [AddrW-1:0] addr, logic signed [DbmW-1:0] dbm,
                                      logic [LenW-1:0] len);
    in_t w;
    w.op          = OP_REPORT;
    w.dev_addr    = addr;
    w.signal_dbm  = dbm;
    w.payload_len = len;
    return w;
  endfunction

  function automatic in_t rand_report(logic [AddrW-1:0] addr);
    return report_word(addr, DbmW'($urandom_range(0, 255)), LenW'($urandom_range(0, 62)));
  endfunction

  // flush with random junk in the unused fields
  function automatic in_t flush_word();
    in_t w;
    w.op          = OP_FLUSH;
    w.dev_addr    = AddrW'({$urandom, $urandom});
    w.signal_dbm  = DbmW'($urandom_range(0, 255));
    w.payload_len = LenW'($urandom_range(0, 62));
    return w;
  endfunction

  initial begin
    logic [AddrW-1:0] pool [PoolSize];
    logic [AddrW-1:0] base;
    logic [AddrW-1:0] run_addr [$];
    logic [AddrW-1:0] a;
    int unsigned      burst;
    int unsigned      n;
    int unsigned      pick;

    rst_ni      = 1'b0;
    in_valid    = 1'b0;
    in_word     = '0;
    idle_en     = 1'b1;
    hold_cycles = 0;
    items_sent  = 0;
    burst       = 0;

    // half the pool are one-bit neighbors of a base address, to catch
    // compare bits that are stuck or dropped
    base = AddrW'({$urandom, $urandom});
    for (int i = 0; i < PoolSize; i++)
      pool[i] = (i < AddrW) ? (base ^ (AddrW'(1) << i)) : AddrW'({$urandom, $urandom});

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part
    send_word(flush_word());                                      // empty flush, no words
    send_word(report_word('0, -8'sd128, 6'd0));                    // slot 0, miss
    send_word(report_word({AddrW{1'b1}}, 8'sd127, 6'd62));         // slot 1, miss
    send_word(report_word('0, 8'sd0, 6'd31));                      // hit on slot 0
    send_word(report_word({(AddrW/2){2'b10}}, -8'sd1, 6'd1));      // slot 2
    send_word(report_word({(AddrW/2){2'b01}}, 8'sd1, 6'd42));      // slot 3
    send_word(report_word({AddrW{1'b1}}, -8'sd60, 6'd21));         // hit on slot 1
    send_word(report_word({(AddrW/2){2'b01}}, -8'sd128, 6'd62));   // hit on the last filled
    send_word(flush_word());                                       // four entries
    send_word(flush_word());                                       // empty again
    send_word(report_word({AddrW{1'b1}}, 8'sd127, 6'd0));          // slot 0 after flush
    send_word(flush_word());                                       // single entry, last set

    // random part: bursts of reports mostly drawn from the pool, with a flush at the
    // end most of the time, two overflow runs past a full table, and one
    // long output hold-off while reports keep coming
    while (items_sent < ItemTarget) begin
      idle_en = (items_sent < CalmFrom);
      if (burst == 2 || burst == 9) begin
        send_word(flush_word());
        run_addr.delete();
        n = TableDepth + $urandom_range(2, 8);
        for (int k = 0; k < n; k++) begin
          a = AddrW'({$urandom, $urandom});
          run_addr.push_back(a);
          send_word(rand_report(a));
          if (k % 9 == 8)
            send_word(rand_report(run_addr[$urandom_range(0, run_addr.size() - 1)]));
        end
        // last slot was overwritten: hit it, then hit the first slot
        send_word(rand_report(run_addr[run_addr.size() - 1]));
        send_word(rand_report(run_addr[0]));
        send_word(flush_word());
      end else begin
        if (burst == 1) hold_cycles = 400;
        n = $urandom_range(4, 30);
        for (int k = 0; k < n; k++) begin
          pick = $urandom_range(0, 99);
          if (pick < 80)
            send_word(rand_report(pool[$urandom_range(0, PoolSize - 1)]));
          else if (pick < 95)
            send_word(rand_report(AddrW'({$urandom, $urandom})));
          else
            send_word(flush_word());
        end
        if ($urandom_range(0, 4) != 0) send_word(flush_word());
      end
      burst++;
    end
    in_valid <= 1'b0;

    // drain, then leave room for a stray word after the last one due
    while (model.pending() != 0) @(negedge clk_i);
    repeat (TableDepth + 40) @(negedge clk_i);

    if (model.faults == 0 && model.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // overall limit, far above a run where every word waits out every stall
  initial begin
    #30ms;
    $display("Verification failed");
    $finish;
  end

endmodule

[scan_report_dedup_cache.f]
rtl/core/srdc_pkg.sv
rtl/core/srdc_store.sv
rtl/core/scan_report_dedup_cache.sv
sim/scan_report_dedup_cache_tb.sv
